### hw/rtl/pell_triple_automaton_check_macros.svh
// Assertion macros for the module that checks its own logic.
`ifndef PELL_TRIPLE_AUTOMATON_CHECK_MACROS_SVH
`define PELL_TRIPLE_AUTOMATON_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/pta_pkg.sv
package pta_pkg;

   localparam int unsigned DIGITS       = 45;
   localparam int unsigned NUM_STATES   = 18;
   localparam int unsigned VALUE_WIDTH  = 56;

   localparam int unsigned SYMBOL_RADIX = 3;
   localparam int unsigned SYMBOLS      = 27;
   localparam int unsigned LANES        = 3;
   localparam int unsigned TABLE_DEPTH  = NUM_STATES * SYMBOLS;
   localparam int unsigned ADDR_WIDTH   = $clog2(TABLE_DEPTH);
   localparam int unsigned STATE_WIDTH  = 5;
   localparam int unsigned SYMBOL_WIDTH = 5;
   localparam int unsigned MASK_WIDTH   = 18;
   localparam int unsigned MASK_SPAN    = 2 ** STATE_WIDTH;
   localparam int unsigned WEIGHT_WIDTH = VALUE_WIDTH + 1;
   localparam int unsigned DIGIT_IDX_WIDTH = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   localparam logic [STATE_WIDTH-1:0] START_STATE_RESET = '0;
   localparam logic [MASK_WIDTH-1:0]  ACCEPT_MASK_RESET = MASK_WIDTH'(8257);

   typedef logic [VALUE_WIDTH-1:0]     value_type;
   typedef logic [WEIGHT_WIDTH-1:0]    weight_type;
   typedef logic [STATE_WIDTH-1:0]     state_type;
   typedef logic [SYMBOL_WIDTH-1:0]    symbol_type;
   typedef logic [MASK_WIDTH-1:0]      mask_type;
   typedef logic [ADDR_WIDTH-1:0]      addr_type;
   typedef logic [DIGIT_IDX_WIDTH-1:0] digit_idx_type;
   typedef logic [1:0]                 digit_type;
   typedef weight_type                 weight_table_type [DIGITS];

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_CHECK = 1'b1
   } mode_type;

   typedef enum logic [0:0] {
      CSR_START_STATE = 1'b0,
      CSR_ACCEPT_MASK = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_RUN,
      FSM_LAST,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic load;
      logic step;
   } digit_cmd_type;

   typedef struct packed {
      logic first;
      logic last;
   } digit_status_type;

   // Pell weights, saturated just above the value range so that they fit the datapath.
   function automatic weight_table_type make_weights();
      weight_table_type table_out;
      longint unsigned  w [DIGITS];
      longint unsigned  limit;
      limit = longint'(1) << VALUE_WIDTH;
      for (int i = 0; i < DIGITS; i++) begin
         if (i == 0) begin
            w[i] = 1;
         end else if (i == 1) begin
            w[i] = 2;
         end else begin
            w[i] = 2 * w[i-1] + w[i-2];
         end
         table_out[i] = weight_type'((w[i] > limit) ? limit : w[i]);
      end
      return table_out;
   endfunction

   localparam weight_table_type PELL_WEIGHTS = make_weights();

endpackage

### hw/rtl/pta_table_ram.sv
module pta_table_ram #(
   parameter int unsigned DEPTH = 486,
   parameter int unsigned WIDTH = 5,
   localparam int unsigned ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pta_digit_unit.sv
module pta_digit_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  pta_pkg::digit_cmd_type    cmd,
   input  pta_pkg::value_type        x_value,
   input  pta_pkg::value_type        y_value,
   input  pta_pkg::value_type        z_value,
   output pta_pkg::symbol_type       symbol,
   output pta_pkg::digit_status_type status
);
   import pta_pkg::*;

   value_type                rest_ff   [LANES];
   value_type                rest_in   [LANES];
   value_type                rest_next [LANES];
   value_type                load_value[LANES];
   logic [WEIGHT_WIDTH:0]    rest_ext  [LANES];
   digit_type                digit     [LANES];
   digit_idx_type            cnt_ff;
   digit_idx_type            cnt_in;
   symbol_type               symbol_ff;
   symbol_type               symbol_in;
   weight_type               weight;
   logic [WEIGHT_WIDTH:0]    weight_ext;
   logic [WEIGHT_WIDTH:0]    two_weight;

   assign load_value[0] = x_value;
   assign load_value[1] = y_value;
   assign load_value[2] = z_value;

   // One greedy Pell digit per lane at the weight selected by the counter.
   always_comb begin
      weight     = PELL_WEIGHTS[cnt_ff];
      weight_ext = {1'b0, weight};
      two_weight = {weight, 1'b0};
      for (int l = 0; l < LANES; l++) begin
         rest_ext[l] = (WEIGHT_WIDTH + 1)'(rest_ff[l]);
         if (rest_ext[l] >= two_weight) begin
            digit[l]     = 2'd2;
            rest_next[l] = rest_ff[l] - VALUE_WIDTH'(two_weight);
         end else if (rest_ext[l] >= weight_ext) begin
            digit[l]     = 2'd1;
            rest_next[l] = rest_ff[l] - VALUE_WIDTH'(weight_ext);
         end else begin
            digit[l]     = 2'd0;
            rest_next[l] = rest_ff[l];
         end
      end
   end

   always_comb begin
      cnt_in    = cnt_ff;
      symbol_in = symbol_ff;
      for (int l = 0; l < LANES; l++) begin
         rest_in[l] = rest_ff[l];
      end
      if (cmd.load) begin
         cnt_in = digit_idx_type'(DIGITS - 1);
         for (int l = 0; l < LANES; l++) begin
            rest_in[l] = load_value[l];
         end
      end else if (cmd.step) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
         end
         for (int l = 0; l < LANES; l++) begin
            rest_in[l] = rest_next[l];
         end
         symbol_in = (SYMBOL_WIDTH'(digit[0]) * SYMBOL_WIDTH'(SYMBOL_RADIX)
                      + SYMBOL_WIDTH'(digit[1])) * SYMBOL_WIDTH'(SYMBOL_RADIX)
                     + SYMBOL_WIDTH'(digit[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
      for (int l = 0; l < LANES; l++) begin
         rest_ff[l] <= rest_in[l];
      end
   end

   assign symbol       = symbol_ff;
   assign status.first = (cnt_ff == digit_idx_type'(DIGITS - 1));
   assign status.last  = (cnt_ff == '0);

endmodule

### hw/rtl/pell_triple_automaton_check.sv
// A load transaction (mode 0) writes one transition table entry, if its state, symbol and
// next state are in range, and returns a zero result in the cycle after acceptance. A check
// transaction (mode 1) splits x, y and z into greedy Pell digits, one digit position per cycle,
// and walks the programmed automaton from start_state over every digit symbol; a start_state
// out of range is not walked and is returned as the final state. The table is read once per
// digit, and each read needs the state returned by the previous registered read. No new
// transaction is taken until a check has finished, while loads can follow each other every
// cycle as their results are taken. The block takes a new transaction only when its sequencer
// is idle and the output register is free or being emptied. The table is not cleared at reset:
// every entry that a check may reach must be loaded first. Register 0 is start_state and
// register 1 is accept_mask; write them only while no transaction is in flight.
`include "pell_triple_automaton_check_macros.svh"

module pell_triple_automaton_check (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  pta_pkg::state_type        req_entry_state,
   input  pta_pkg::symbol_type       req_entry_symbol,
   input  pta_pkg::state_type        req_entry_next,
   input  pta_pkg::value_type        req_x_value,
   input  pta_pkg::value_type        req_y_value,
   input  pta_pkg::value_type        req_z_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_accepted,
   output pta_pkg::state_type        rsp_final_state,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [0:0]                csr_index,
   input  pta_pkg::mask_type         csr_data
);
   import pta_pkg::*;

   fsm_type          fsm_ff;
   fsm_type          fsm_in;
   state_type        start_state_ff;
   mask_type         accept_mask_ff;
   logic             use_start_ff;
   logic             use_start_in;
   logic             rsp_valid_ff;
   logic             rsp_accepted_ff;
   state_type        rsp_final_state_ff;
   logic             out_free;
   logic             req_fire;
   logic             load_fire;
   logic             check_fire;
   logic             check_offer;
   logic             finish_fire;
   logic             walk_en;
   logic             start_oor;
   logic             run_last;
   logic             load_rsp_ok;
   logic             table_wr_en;
   addr_type         table_wr_addr;
   logic             table_rd_en;
   addr_type         table_rd_addr;
   state_type        table_rd_data;
   state_type        cur_state;
   state_type        final_state;
   logic [MASK_SPAN-1:0] mask_ext;
   digit_cmd_type    digit_cmd;
   digit_status_type digit_status;
   symbol_type       digit_symbol;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= START_STATE_RESET;
         accept_mask_ff <= ACCEPT_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_START_STATE: start_state_ff <= csr_data[STATE_WIDTH-1:0];
            CSR_ACCEPT_MASK: accept_mask_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign load_fire   = req_fire && (mode_type'(req_mode) == MODE_LOAD);
   assign check_fire  = req_fire && (mode_type'(req_mode) == MODE_CHECK);
   assign check_offer = req_valid && out_free && (mode_type'(req_mode) == MODE_CHECK);
   assign start_oor   = (start_state_ff >= state_type'(NUM_STATES));

   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_IDLE: begin
            if (check_fire) begin
               fsm_in = FSM_RUN;
            end
         end
         FSM_RUN: begin
            if (digit_status.last) begin
               fsm_in = FSM_LAST;
            end
         end
         FSM_LAST: begin
            fsm_in = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (out_free) begin
               fsm_in = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      digit_cmd.load = 1'b0;
      digit_cmd.step = 1'b0;
      walk_en        = 1'b0;
      finish_fire    = 1'b0;
      case (fsm_ff)
         FSM_IDLE: begin
            req_ready      = out_free;
            digit_cmd.load = check_offer;
         end
         FSM_RUN: begin
            digit_cmd.step = 1'b1;
            walk_en        = !digit_status.first;
         end
         FSM_LAST: begin
            walk_en = 1'b1;
         end
         FSM_FINISH: begin
            finish_fire = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= FSM_IDLE;
      end else begin
         fsm_ff <= fsm_in;
      end
   end

   always_comb begin
      use_start_in = use_start_ff;
      if (check_fire) begin
         use_start_in = 1'b1;
      end else if (walk_en) begin
         use_start_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_start_ff <= 1'b0;
      end else begin
         use_start_ff <= use_start_in;
      end
   end

   assign table_wr_en   = load_fire
                          && (req_entry_state < state_type'(NUM_STATES))
                          && (req_entry_symbol < symbol_type'(SYMBOLS))
                          && (req_entry_next < state_type'(NUM_STATES));
   assign table_wr_addr = addr_type'(req_entry_state) * addr_type'(SYMBOLS)
                          + addr_type'(req_entry_symbol);

   assign cur_state     = use_start_ff ? start_state_ff : table_rd_data;
   assign table_rd_en   = walk_en && !start_oor;
   assign table_rd_addr = addr_type'(cur_state) * addr_type'(SYMBOLS)
                          + addr_type'(digit_symbol);

   pta_digit_unit u_digit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (digit_cmd),
      .x_value (req_x_value),
      .y_value (req_y_value),
      .z_value (req_z_value),
      .symbol  (digit_symbol),
      .status  (digit_status)
   );

   pta_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (STATE_WIDTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (table_wr_en),
      .wr_addr (table_wr_addr),
      .wr_data (req_entry_next),
      .rd_en   (table_rd_en),
      .rd_addr (table_rd_addr),
      .rd_data (table_rd_data)
   );

   assign final_state = start_oor ? start_state_ff : cur_state;
   assign mask_ext    = MASK_SPAN'(accept_mask_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_fire || finish_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         rsp_accepted_ff    <= 1'b0;
         rsp_final_state_ff <= '0;
      end else if (finish_fire) begin
         rsp_accepted_ff    <= mask_ext[final_state];
         rsp_final_state_ff <= final_state;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_final_state = rsp_final_state_ff;

   assign run_last    = (fsm_ff == FSM_RUN) && digit_status.last;
   assign load_rsp_ok = rsp_valid && !rsp_accepted && (rsp_final_state == '0);

   `PTA_ASSERT_SAME(a_ready_only_idle, req_ready, fsm_ff == FSM_IDLE, "Ready outside idle.")
   `PTA_ASSERT_NEXT(a_check_starts, check_fire, fsm_ff == FSM_RUN, "Check did not start.")
   `PTA_ASSERT_NEXT(a_last_digit, run_last, fsm_ff == FSM_LAST, "No final walk step.")
   `PTA_ASSERT_NEXT(a_load_result, load_fire, load_rsp_ok, "Load gave a wrong result.")
   `PTA_ASSERT_SAME(a_walk_from_table, fsm_ff == FSM_FINISH, !use_start_ff, "No table step.")

endmodule

### tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pta_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES    = 400;

   typedef struct packed {
      mode_type   mode;
      state_type  entry_state;
      symbol_type entry_symbol;
      state_type  entry_next;
      value_type  x_value;
      value_type  y_value;
      value_type  z_value;
   } pell_item_type;

   typedef struct packed {
      logic      accepted;
      state_type final_state;
   } verdict_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic       req_mode         = 1'b0;
   state_type  req_entry_state  = '0;
   symbol_type req_entry_symbol = '0;
   state_type  req_entry_next   = '0;
   value_type  req_x_value      = '0;
   value_type  req_y_value      = '0;
   value_type  req_z_value      = '0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic       rsp_accepted;
   state_type  rsp_final_state;
   logic       csr_valid        = 1'b0;
   logic       csr_ready;
   logic [0:0] csr_index        = '0;
   mask_type   csr_data         = '0;

   pell_item_type   pending_items [$];
   verdict_type     expected_verdicts [$];
   state_type       next_state_table [NUM_STATES * SYMBOLS];
   longint unsigned pell_weight [DIGITS];
   state_type       start_cfg;
   mask_type        accept_cfg;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_requests      = 0;
   int unsigned hold_served        = 0;
   int unsigned hold_left          = 0;
   int unsigned mismatch_count     = 0;
   int unsigned quiet_cycles       = 0;

   pell_triple_automaton_check dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_entry_state  (req_entry_state),
      .req_entry_symbol (req_entry_symbol),
      .req_entry_next   (req_entry_next),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .req_z_value      (req_z_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_final_state  (rsp_final_state),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // A load transaction updates the table copy; a check transaction walks it digit by digit.
   function automatic verdict_type predict_verdict(pell_item_type item);
      verdict_type     v;
      longint unsigned rest [3];
      int unsigned     cur;
      int unsigned     sym;
      int unsigned     digit;
      v.accepted    = 1'b0;
      v.final_state = '0;
      if (item.mode == MODE_LOAD) begin
         if (item.entry_state < NUM_STATES && item.entry_symbol < SYMBOLS &&
             item.entry_next < NUM_STATES) begin
            next_state_table[item.entry_state * SYMBOLS + item.entry_symbol] = item.entry_next;
         end
         return v;
      end
      rest[0] = item.x_value;
      rest[1] = item.y_value;
      rest[2] = item.z_value;
      cur = start_cfg;
      for (int i = DIGITS - 1; i >= 0; i--) begin
         sym = 0;
         for (int k = 0; k < 3; k++) begin
            if (rest[k] >= 2 * pell_weight[i]) begin
               rest[k] -= 2 * pell_weight[i];
               digit = 2;
            end else if (rest[k] >= pell_weight[i]) begin
               rest[k] -= pell_weight[i];
               digit = 1;
            end else begin
               digit = 0;
            end
            sym = sym * 3 + digit;
         end
         if (cur < NUM_STATES) begin
            cur = next_state_table[cur * SYMBOLS + sym];
         end
      end
      v.final_state = state_type'(cur);
      v.accepted    = (cur < MASK_WIDTH) ? accept_cfg[cur] : 1'b0;
      return v;
   endfunction

   function automatic value_type pick_value();
      longint unsigned base;
      int unsigned     k;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return value_type'($urandom_range(0, 300));
         4, 5: begin
            k = $urandom_range(0, DIGITS - 1);
            base = ($urandom_range(0, 1) != 0) ? 2 * pell_weight[k] : pell_weight[k];
            return value_type'(base + $urandom_range(0, 2) - 1);
         end
         default: return value_type'({$urandom, $urandom});
      endcase
   endfunction

   function automatic void queue_load(int unsigned es, int unsigned sym, int unsigned nx);
      pell_item_type item;
      item.mode         = MODE_LOAD;
      item.entry_state  = state_type'(es);
      item.entry_symbol = symbol_type'(sym);
      item.entry_next   = state_type'(nx);
      item.x_value      = value_type'({$urandom, $urandom});
      item.y_value      = value_type'({$urandom, $urandom});
      item.z_value      = value_type'({$urandom, $urandom});
      pending_items = {pending_items, item};
   endfunction

   function automatic void queue_check(value_type x, value_type y, value_type z);
      pell_item_type item;
      item.mode         = MODE_CHECK;
      item.entry_state  = state_type'($urandom_range(0, 31));
      item.entry_symbol = symbol_type'($urandom_range(0, 31));
      item.entry_next   = state_type'($urandom_range(0, 31));
      item.x_value      = x;
      item.y_value      = y;
      item.z_value      = z;
      pending_items = {pending_items, item};
   endfunction

   function automatic void queue_random_item();
      int unsigned roll;
      int unsigned es;
      int unsigned sym;
      int unsigned nx;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         queue_check(pick_value(), pick_value(), pick_value());
      end else if (roll < 94) begin
         queue_load($urandom_range(0, NUM_STATES - 1), $urandom_range(0, SYMBOLS - 1),
                    $urandom_range(0, NUM_STATES - 1));
      end else begin
         es  = $urandom_range(0, 31);
         sym = $urandom_range(0, 31);
         nx  = $urandom_range(0, 31);
         case ($urandom_range(0, 2))
            0: es = $urandom_range(NUM_STATES, 31);
            1: sym = $urandom_range(SYMBOLS, 31);
            default: nx = $urandom_range(NUM_STATES, 31);
         endcase
         queue_load(es, sym, nx);
      end
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < 10) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   task automatic write_register(csr_index_type idx, mask_type data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_START_STATE) begin
         start_cfg = data[STATE_WIDTH-1:0];
      end else begin
         accept_cfg = data;
      end
      @(posedge clock);
   endtask

   // Sampled away from the rising edge so that every update of that edge is already visible.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || req_valid || expected_verdicts.size() != 0);
      @(posedge clock);
   endtask

   always @(posedge clock) begin : drive_requests
      pell_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            item = pending_items.pop_front();
            req_mode         <= item.mode;
            req_entry_state  <= item.entry_state;
            req_entry_symbol <= item.entry_symbol;
            req_entry_next   <= item.entry_next;
            req_x_value      <= item.x_value;
            req_y_value      <= item.y_value;
            req_z_value      <= item.z_value;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_ready   <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      verdict_type   want;
      pell_item_type seen;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("result accepted=%0b final_state=%0d with none pending",
                                         rsp_accepted, rsp_final_state));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_accepted !== want.accepted || rsp_final_state !== want.final_state) begin
                  report_mismatch($sformatf(
                     "expected accepted=%0b final_state=%0d, got accepted=%0b final_state=%0d",
                     want.accepted, want.final_state, rsp_accepted, rsp_final_state));
               end
            end
         end
         if (req_valid && req_ready) begin
            seen.mode         = mode_type'(req_mode);
            seen.entry_state  = req_entry_state;
            seen.entry_symbol = req_entry_symbol;
            seen.entry_next   = req_entry_next;
            seen.x_value      = req_x_value;
            seen.y_value      = req_y_value;
            seen.z_value      = req_z_value;
            expected_verdicts = {expected_verdicts, predict_verdict(seen)};
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL pell_triple_automaton_check");
         $finish;
      end
   end

   initial begin : stimulus
      mask_type    start_data;
      mask_type    mask_data;
      int unsigned item_count;
      pell_weight[0] = 1;
      pell_weight[1] = 2;
      for (int i = 2; i < DIGITS; i++) begin
         pell_weight[i] = 2 * pell_weight[i-1] + pell_weight[i-2];
      end
      start_cfg  = START_STATE_RESET;
      accept_cfg = ACCEPT_MASK_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Every table entry is loaded before any check transaction can read it.
      for (int s = 0; s < NUM_STATES; s++) begin
         for (int sym = 0; sym < SYMBOLS; sym++) begin
            queue_load(s, sym, $urandom_range(0, NUM_STATES - 1));
         end
      end

      queue_load(NUM_STATES - 1, SYMBOLS - 1, NUM_STATES - 1);
      queue_load(0, 0, 0);
      queue_load(NUM_STATES, 5, 3);
      queue_load(31, 31, 31);
      queue_load(4, SYMBOLS, 2);
      queue_load(2, 10, NUM_STATES);
      queue_check('0, '0, '0);
      queue_check('1, '1, '1);
      queue_check('1, '0, '0);
      queue_check('0, '1, '0);
      queue_check('0, '0, '1);
      queue_check(value_type'(pell_weight[DIGITS-1]), value_type'(2 * pell_weight[DIGITS-2]),
                  value_type'(pell_weight[DIGITS-2] - 1));
      queue_check(value_type'(pell_weight[0]), value_type'(pell_weight[1]),
                  value_type'(pell_weight[2]));
      queue_check(value_type'(pell_weight[DIGITS-1] - 1), value_type'(pell_weight[10]),
                  value_type'(2 * pell_weight[10]));
      queue_check(56'hAAAAAAAAAAAAAA, 56'h55555555555555, 56'hFF00FF00FF00FF);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         item_count = 250;
         case (p)
            0: begin
               start_data = 18'd17;
               mask_data  = '1;
            end
            1: begin
               start_data = '0;
               mask_data  = '0;
            end
            2: begin
               start_data = 18'd31;
               mask_data  = mask_type'($urandom_range(0, 262143));
               item_count = 60;
            end
            3: begin
               start_data = 18'h3FFE5;
               mask_data  = 18'h2AAAA;
            end
            4: begin
               start_data = 18'd18;
               mask_data  = 18'h15555;
               item_count = 60;
            end
            5: begin
               start_data = mask_type'(($urandom_range(0, 8191) << 5) |
                                       $urandom_range(0, NUM_STATES - 1));
               mask_data  = mask_type'($urandom_range(0, 262143));
            end
            default: begin
               start_data = mask_type'($urandom_range(0, NUM_STATES - 1));
               mask_data  = mask_type'($urandom_range(0, 262143));
            end
         endcase
         case (p % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 54;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 54;
            end
            default: begin
               sender_idle_pct    = 22;
               receiver_stall_pct = 22;
            end
         endcase
         write_register(CSR_START_STATE, start_data);
         write_register(CSR_ACCEPT_MASK, mask_data);
         repeat (item_count) queue_random_item();
         if (p == 0) begin
            hold_requests++;
         end
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("PASS pell_triple_automaton_check");
      end else begin
         $display("FAIL pell_triple_automaton_check");
      end
      $finish;
   end

endmodule
